// File: src/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and the digit-to-ASCII function for the radix
// digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int MAG_W   = 31;
    localparam int RADIX_W = 6;
    localparam int LIMIT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 6;

    // Limits
    localparam logic [RADIX_W-1:0] RADIX_MIN       = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX       = 6'd36;
    localparam logic [LIMIT_W-1:0] CHAR_LIMIT_RST  = 6'd32;

    // Divider: bits of the dividend retired per cycle, divider steps per digit
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = VALUE_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // ASCII
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_TOP  = 6'd35;

    // Request class decided by the front
    typedef enum logic [1:0] {
        KIND_BAD   = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_CONV  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [MAG_W-1:0]     magnitude;
        logic [RADIX_W-1:0]   radix;
    } cmd_t;

    // Digit 0..35 to '0'-'9','A'-'Z'; anything higher clamps to 'Z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (d <= DIGIT_TOP) begin
            c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end else begin
            c = CHAR_Z;
        end
        return c;
    endfunction

endpackage

// File: src/rdc_front.sv
// ----------------------------------------------------------------------------
// rdc_front
// Input side: holds the char_limit register, classifies each request as
// bad radix, empty or a real conversion, and pushes it into the queue.
// ----------------------------------------------------------------------------
module rdc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [rdc_pkg::VALUE_W-1:0] value,
    input  logic [rdc_pkg::RADIX_W-1:0]     radix,
    // config channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rdc_pkg::LIMIT_W-1:0]     cfg_data,
    // queue side
    input  logic                            q_full,
    output logic                            q_push,
    output rdc_pkg::cmd_t                   q_cmd,
    // current limit for the back end
    output logic [rdc_pkg::LIMIT_W-1:0]     char_limit
);

    logic [rdc_pkg::LIMIT_W-1:0] char_limit_reg;

    // Config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit_reg <= rdc_pkg::CHAR_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            char_limit_reg <= cfg_data;
        end
    end

    assign char_limit = char_limit_reg;

    // Handshake: stall only when the queue is full
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classification; radix check comes first
    always_comb
    begin
        q_cmd.magnitude = value[rdc_pkg::MAG_W-1:0];
        q_cmd.radix     = radix;
        if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX)
        begin
            q_cmd.kind = rdc_pkg::KIND_BAD;
        end
        else if (value[rdc_pkg::VALUE_W-1] || value == '0 || char_limit_reg == '0)
        begin
            q_cmd.kind = rdc_pkg::KIND_EMPTY;
        end
        else
        begin
            q_cmd.kind = rdc_pkg::KIND_CONV;
        end
    end

endmodule

// File: src/rdc_queue.sv
// ----------------------------------------------------------------------------
// rdc_queue
// Two-entry request queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module rdc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rdc_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output rdc_pkg::cmd_t   pop_cmd
);

    rdc_pkg::cmd_t                 slot_reg [rdc_pkg::QUEUE_DEPTH];
    logic [rdc_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [rdc_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [rdc_pkg::QCNT_W-1:0]    count_reg;
    logic [rdc_pkg::QCNT_W-1:0]    count_next;

    assign full    = (count_reg == rdc_pkg::QCNT_W'(rdc_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/rdc_back.sv
// ----------------------------------------------------------------------------
// rdc_back
// Conversion engine: repeated division by the radix (eight quotient bits a
// cycle) into a ring digit store, then read-back most significant first.
// ----------------------------------------------------------------------------
module rdc_back #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // queue side
    input  logic                            q_valid,
    input  rdc_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    input  logic [rdc_pkg::LIMIT_W-1:0]     char_limit,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rdc_pkg::CHAR_W-1:0]      char_code,
    output logic                            last,
    output logic                            empty_res,
    output logic                            bad_radix
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam logic [AW-1:0] ADDR_TOP = AW'(MAX_DIGITS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [rdc_pkg::VALUE_W-1:0]     quot_reg;
    logic [rdc_pkg::VALUE_W-1:0]     quot_next;
    logic [rdc_pkg::RADIX_W-1:0]     rem_reg;
    logic [rdc_pkg::RADIX_W-1:0]     rem_next;
    logic [rdc_pkg::RADIX_W-1:0]     radix_reg;
    logic [rdc_pkg::STEP_W-1:0]      step_reg;
    logic [rdc_pkg::CNT_W-1:0]       digit_count_reg;
    logic [rdc_pkg::CNT_W-1:0]       count_inc;
    logic [rdc_pkg::CNT_W-1:0]       kept;
    logic [rdc_pkg::CNT_W-1:0]       emit_cnt;
    logic [rdc_pkg::CNT_W-1:0]       left_reg;
    logic [AW-1:0]                   wptr_reg;
    logic [AW-1:0]                   rptr_reg;
    logic                            res_last_reg;
    logic                            res_empty_reg;
    logic                            res_bad_reg;
    logic                            digit_done;
    logic                            conv_done;

    // Digit store: one write, one registered read
    logic [rdc_pkg::RADIX_W-1:0]     digit_store [MAX_DIGITS];
    logic [rdc_pkg::RADIX_W-1:0]     rd_data_reg;

    // One divider cycle: eight restoring steps on a 6-bit remainder
    always_comb
    begin : div_step
        logic [rdc_pkg::RADIX_W:0] t;
        t         = '0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        for (int i = 0; i < rdc_pkg::DIV_BITS; i++)
        begin
            t         = {rem_next, quot_next[rdc_pkg::VALUE_W-1]};
            quot_next = {quot_next[rdc_pkg::VALUE_W-2:0], 1'b0};
            if (t >= {1'b0, radix_reg})
            begin
                quot_next[0] = 1'b1;
                rem_next     = rdc_pkg::RADIX_W'(t - {1'b0, radix_reg});
            end
            else
            begin
                rem_next = t[rdc_pkg::RADIX_W-1:0];
            end
        end
    end

    assign digit_done = (state_reg == S_DIV) && (step_reg == rdc_pkg::STEP_W'(rdc_pkg::DIV_STEPS - 1));
    assign conv_done  = digit_done && (quot_next == '0);

    // Characters to emit: digits kept in the ring, capped by the limit
    assign count_inc = digit_count_reg + 1'b1;
    assign kept      = (int'(count_inc) < MAX_DIGITS) ? count_inc : rdc_pkg::CNT_W'(MAX_DIGITS);
    assign emit_cnt  = (kept < rdc_pkg::CNT_W'(char_limit)) ? kept : rdc_pkg::CNT_W'(char_limit);

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_cmd.kind == rdc_pkg::KIND_CONV) ? S_DIV : S_OUT;
                end
            end
            S_DIV:
            begin
                if (conv_done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = res_last_reg ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            quot_reg        <= '0;
            rem_reg         <= '0;
            radix_reg       <= '0;
            step_reg        <= '0;
            digit_count_reg <= '0;
            left_reg        <= '0;
            wptr_reg        <= '0;
            rptr_reg        <= '0;
            res_last_reg    <= 1'b0;
            res_empty_reg   <= 1'b0;
            res_bad_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                // Take the next request
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        res_last_reg  <= 1'b1;
                        res_empty_reg <= (q_cmd.kind != rdc_pkg::KIND_CONV);
                        res_bad_reg   <= (q_cmd.kind == rdc_pkg::KIND_BAD);
                        if (q_cmd.kind == rdc_pkg::KIND_EMPTY)
                        begin
                            digit_count_reg <= '0;
                            quot_reg        <= '0;
                        end
                        else if (q_cmd.kind == rdc_pkg::KIND_CONV)
                        begin
                            quot_reg        <= {1'b0, q_cmd.magnitude};
                            radix_reg       <= q_cmd.radix;
                            rem_reg         <= '0;
                            step_reg        <= '0;
                            digit_count_reg <= '0;
                            wptr_reg        <= '0;
                        end
                    end
                end
                // Divide; a digit completes on the last divider step
                S_DIV:
                begin
                    quot_reg <= quot_next;
                    step_reg <= step_reg + 1'b1;
                    if (digit_done)
                    begin
                        rem_reg         <= '0;
                        digit_count_reg <= count_inc;
                        wptr_reg        <= (wptr_reg == ADDR_TOP) ? '0 : wptr_reg + 1'b1;
                        if (conv_done)
                        begin
                            left_reg <= emit_cnt;
                            rptr_reg <= wptr_reg;
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                    end
                end
                // Fetch one digit, walking the ring downward
                S_RD:
                begin
                    rptr_reg     <= (rptr_reg == '0) ? ADDR_TOP : rptr_reg - 1'b1;
                    left_reg     <= left_reg - 1'b1;
                    res_last_reg <= (left_reg == rdc_pkg::CNT_W'(1));
                end
                S_OUT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Store write and read port
    always_ff @(posedge clk)
    begin
        if (digit_done)
        begin
            digit_store[wptr_reg] <= rem_next;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= digit_store[rptr_reg];
        end
    end

    // Result port
    assign out_valid = (state_reg == S_OUT);
    assign char_code = res_empty_reg ? rdc_pkg::CHAR_NUL : rdc_pkg::digit_char(rd_data_reg);
    assign last      = res_last_reg;
    assign empty_res = res_empty_reg;
    assign bad_radix = res_bad_reg;

endmodule

// File: src/radix_digit_converter_unit.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// Signed 32-bit integer to base-N ASCII digit stream, most significant first.
// ----------------------------------------------------------------------------
// One request at a time is converted. A positive value leaves the two-entry
// request queue, then passes the divider (eight quotient bits per cycle),
// then each emitted character passes the registered digit store read and
// the result state, which holds while out_stall is high. A bad-radix or
// empty request shows its single result in the cycle right after the back
// end takes it from the queue. New requests are taken into the queue, until
// it is full, while the back end converts or waits on a stalled result.
module radix_digit_converter_unit #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rdc_pkg::VALUE_W-1:0]  value,
    input  logic [rdc_pkg::RADIX_W-1:0]         radix,
    // config channel (char_limit)
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdc_pkg::LIMIT_W-1:0]         cfg_data,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rdc_pkg::CHAR_W-1:0]          char_code,
    output logic                                last,
    output logic                                empty_res,
    output logic                                bad_radix
);

    logic                         q_full;
    logic                         q_push;
    rdc_pkg::cmd_t                push_cmd;
    logic                         q_pop;
    logic                         q_valid;
    rdc_pkg::cmd_t                pop_cmd;
    logic [rdc_pkg::LIMIT_W-1:0]  char_limit;

    // Front: config and classification
    rdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .radix      (radix),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .char_limit (char_limit)
    );

    // Request queue
    rdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .pop_cmd  (pop_cmd)
    );

    // Back: divider, digit store, emission
    rdc_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .char_limit (char_limit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last       (last),
        .empty_res  (empty_res),
        .bad_radix  (bad_radix)
    );

endmodule

// File: src/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks on the result stream of the converter, bound to the top.
// ----------------------------------------------------------------------------
module rdc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [rdc_pkg::CHAR_W-1:0]      char_code,
    input  logic                            last,
    input  logic                            empty_res,
    input  logic                            bad_radix
);

    // A bad-radix result is a lone empty result
    a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_radix |-> empty_res && last && char_code == rdc_pkg::CHAR_NUL)
        else $error("bad_radix result not a single empty result");

    // An empty result ends the request and carries no character
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && char_code == rdc_pkg::CHAR_NUL)
        else $error("empty result not final or not NUL");

    // Character results are digits or capital letters
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res |->
            (char_code >= rdc_pkg::CHAR_ZERO && char_code <= rdc_pkg::CHAR_NINE) ||
            (char_code >= rdc_pkg::CHAR_A && char_code <= rdc_pkg::CHAR_Z))
        else $error("character outside 0-9/A-Z");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last)
            && $stable(empty_res) && $stable(bad_radix))
        else $error("stalled result changed");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last),
    .empty_res (empty_res),
    .bad_radix (bad_radix)
);
